### design/lbm_pkg.sv
// ----------------------------------------------------------------------------
// lbm_pkg: shared definitions for the LED / button pin multiplexer
// Command codes, register indexes, field widths and the types that pass
// between the pattern player, the panel and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package lbm_pkg;

  // Pins shared by one LED and one active-low button each.
  localparam int NUM_LEDS  = 4;
  localparam int LED_IDX_W = 2;

  // Defaults for the top-level parameters.
  localparam int MAX_STEPS_DEF = 8;
  localparam int TIME_BITS_DEF = 16;

  // Field widths of the input beat.
  localparam int CMD_W      = 3;
  localparam int STEP_IDX_W = 3;
  localparam int DUR_W      = 16;
  localparam int PLEN_W     = 4;

  // Configuration port.
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_TICKS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TICKS  = 1'd1;

  localparam logic [CFG_W-1:0] DISPLAY_TICKS_RST = 16'd5;
  localparam logic [CFG_W-1:0] SETTLE_TICKS_RST  = 16'd1;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_TICK  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SET   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_START = 3'd3;
  localparam logic [CMD_W-1:0] CMD_STOP  = 3'd4;

  // One input beat.
  typedef struct packed {
    logic [CMD_W-1:0]      cmd;
    logic [LED_IDX_W-1:0]  led_index;
    logic                  led_on;
    logic [STEP_IDX_W-1:0] step_index;
    logic [LED_IDX_W-1:0]  step_led;
    logic [DUR_W-1:0]      step_duration;
    logic [PLEN_W-1:0]     pattern_length;
    logic [NUM_LEDS-1:0]   pin_levels;
  } lbm_item_t;

  // Player status after a beat.
  typedef struct packed {
    logic [NUM_LEDS-1:0] lit_mask;
    logic                playing;
  } lbm_play_stat_t;

  // Panel status after a beat.
  typedef struct packed {
    logic [NUM_LEDS-1:0] drive;
    logic [NUM_LEDS-1:0] pressed;
    logic                in_scan;
  } lbm_panel_stat_t;

endpackage

`default_nettype wire

### design/lbm_player.sv
// ----------------------------------------------------------------------------
// lbm_player: LED mask and pattern player
// Owns the requested LED mask, the pattern table and the playback counters.
// Computes the state after one beat and commits it when the beat advances.
// ----------------------------------------------------------------------------
`default_nettype none

module lbm_player #(
  parameter int MAX_STEPS = lbm_pkg::MAX_STEPS_DEF,
  parameter int TIME_BITS = lbm_pkg::TIME_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   upd,
  input  wire lbm_pkg::lbm_item_t     item,
  output lbm_pkg::lbm_play_stat_t     stat_nxt
);
  import lbm_pkg::*;

  localparam int LEN_W = $clog2(MAX_STEPS + 1);
  localparam int IDX_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int CW    = (TIME_BITS > DUR_W) ? TIME_BITS : DUR_W;
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  // Pattern table, undefined until loaded.
  logic [LED_IDX_W-1:0] led_tab_r [MAX_STEPS];
  logic [DUR_W-1:0]     dur_tab_r [MAX_STEPS];

  // Playback state.
  logic [NUM_LEDS-1:0]  mask_r, mask_nxt;
  logic                 playing_r, playing_nxt;
  logic [LEN_W-1:0]     len_r, len_nxt;
  logic [LEN_W-1:0]     cur_r, cur_nxt;
  logic [TIME_BITS-1:0] el_r, el_nxt;

  // Copy of the table entry at the current step.
  logic [LED_IDX_W-1:0] cur_led_r, cur_led_nxt;
  logic [DUR_W-1:0]     cur_dur_r, cur_dur_nxt;

  logic [LEN_W:0]       nstep;
  logic [IDX_W-1:0]     nidx;
  logic [IDX_W-1:0]     widx;
  logic                 load_ok;
  logic [TIME_BITS-1:0] el_inc;

  assign nstep   = {1'b0, cur_r} + (LEN_W + 1)'(1);
  assign nidx    = IDX_W'(nstep);
  assign widx    = IDX_W'(item.step_index);
  assign load_ok = (32'(item.step_index) < MAX_STEPS) && (32'(item.step_led) < NUM_LEDS);
  assign el_inc  = (el_r == TIME_MAX) ? el_r : el_r + TIME_BITS'(1);

  // Next state for one beat.
  always_comb begin
    mask_nxt    = mask_r;
    playing_nxt = playing_r;
    len_nxt     = len_r;
    cur_nxt     = cur_r;
    el_nxt      = el_r;
    cur_led_nxt = cur_led_r;
    cur_dur_nxt = cur_dur_r;
    case (item.cmd)
      CMD_TICK: begin
        if (playing_r) begin
          if ((cur_r >= len_r) || (32'(cur_r) >= MAX_STEPS)) begin
            playing_nxt = 1'b0;
          end else if (CW'(el_inc) >= CW'(cur_dur_r)) begin
            // Current entry is done: drop its LED and move on.
            mask_nxt[cur_led_r] = 1'b0;
            cur_nxt = LEN_W'(nstep);
            el_nxt  = '0;
            if ((nstep < (LEN_W + 1)'(len_r)) && (32'(nstep) < MAX_STEPS)) begin
              mask_nxt[led_tab_r[nidx]] = 1'b1;
              cur_led_nxt = led_tab_r[nidx];
              cur_dur_nxt = dur_tab_r[nidx];
            end else begin
              playing_nxt = 1'b0;
            end
          end else begin
            el_nxt = el_inc;
          end
        end
      end
      CMD_SET: begin
        if (32'(item.led_index) < NUM_LEDS) begin
          mask_nxt[item.led_index] = item.led_on;
        end
      end
      CMD_LOAD: begin
        // Keep the current-step copy in line with the table.
        if (load_ok && (32'(item.step_index) == 32'(cur_r))) begin
          cur_led_nxt = item.step_led;
          cur_dur_nxt = item.step_duration;
        end
      end
      CMD_START: begin
        if (item.pattern_length != '0) begin
          if (32'(item.pattern_length) > MAX_STEPS) begin
            len_nxt = LEN_W'(MAX_STEPS);
          end else begin
            len_nxt = LEN_W'(item.pattern_length);
          end
          cur_nxt     = '0;
          el_nxt      = '0;
          playing_nxt = 1'b1;
          mask_nxt[led_tab_r[0]] = 1'b1;
          cur_led_nxt = led_tab_r[0];
          cur_dur_nxt = dur_tab_r[0];
        end
      end
      CMD_STOP: begin
        if (playing_r) begin
          if (32'(cur_r) < MAX_STEPS) begin
            mask_nxt[cur_led_r] = 1'b0;
          end
          playing_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r    <= '0;
      playing_r <= 1'b0;
      len_r     <= '0;
      cur_r     <= '0;
      el_r      <= '0;
    end else if (upd) begin
      mask_r    <= mask_nxt;
      playing_r <= playing_nxt;
      len_r     <= len_nxt;
      cur_r     <= cur_nxt;
      el_r      <= el_nxt;
    end
  end

  // Table and current-entry copy carry no reset.
  always_ff @(posedge clk) begin
    if (upd) begin
      cur_led_r <= cur_led_nxt;
      cur_dur_r <= cur_dur_nxt;
      if ((item.cmd == CMD_LOAD) && load_ok) begin
        led_tab_r[widx] <= item.step_led;
        dur_tab_r[widx] <= item.step_duration;
      end
    end
  end

  assign stat_nxt.lit_mask = mask_nxt;
  assign stat_nxt.playing  = playing_nxt;

endmodule

`default_nettype wire

### design/lbm_panel.sv
// ----------------------------------------------------------------------------
// lbm_panel: display and scan phases of the shared pins
// Drives the LED mask during display, releases the pins to settle, then
// latches the active-low button levels. Holds both timing registers.
// ----------------------------------------------------------------------------
`default_nettype none

module lbm_panel #(
  parameter int TIME_BITS = lbm_pkg::TIME_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [lbm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [lbm_pkg::CFG_W-1:0]         cfg_wdata,
  input  wire logic                              upd,
  input  wire logic                              tick,
  input  wire logic [lbm_pkg::NUM_LEDS-1:0]      pins,
  input  wire logic [lbm_pkg::NUM_LEDS-1:0]      mask,
  output lbm_pkg::lbm_panel_stat_t               stat_nxt
);
  import lbm_pkg::*;

  localparam int CW = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  logic [CFG_W-1:0]     disp_r;
  logic [CFG_W-1:0]     settle_r;
  logic                 phase_r, phase_nxt;
  logic [TIME_BITS-1:0] el_r, el_nxt;
  logic [NUM_LEDS-1:0]  drive_r, drive_nxt;
  logic [NUM_LEDS-1:0]  pressed_r, pressed_nxt;
  logic [TIME_BITS-1:0] el_inc;

  assign el_inc = (el_r == TIME_MAX) ? el_r : el_r + TIME_BITS'(1);

  // Timing registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disp_r   <= DISPLAY_TICKS_RST;
      settle_r <= SETTLE_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DISPLAY_TICKS: disp_r   <= cfg_wdata;
        REG_SETTLE_TICKS:  settle_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Phase sequencing on a tick.
  always_comb begin
    phase_nxt   = phase_r;
    el_nxt      = el_r;
    drive_nxt   = drive_r;
    pressed_nxt = pressed_r;
    if (tick) begin
      if (!phase_r) begin
        if (CW'(el_inc) < CW'(disp_r)) begin
          drive_nxt = mask;
          el_nxt    = el_inc;
        end else begin
          drive_nxt = '0;
          phase_nxt = 1'b1;
          el_nxt    = '0;
        end
      end else if (CW'(el_inc) < CW'(settle_r)) begin
        el_nxt = el_inc;
      end else begin
        pressed_nxt = ~pins;
        drive_nxt   = mask;
        phase_nxt   = 1'b0;
        el_nxt      = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= 1'b0;
      el_r      <= '0;
      drive_r   <= '0;
      pressed_r <= '0;
    end else if (upd) begin
      phase_r   <= phase_nxt;
      el_r      <= el_nxt;
      drive_r   <= drive_nxt;
      pressed_r <= pressed_nxt;
    end
  end

  assign stat_nxt.drive   = drive_nxt;
  assign stat_nxt.pressed = pressed_nxt;
  assign stat_nxt.in_scan = phase_nxt;

endmodule

`default_nettype wire

### design/led_button_mux_with_pattern_player_unit.sv
// ----------------------------------------------------------------------------
// led_button_mux_with_pattern_player_unit: shared-pin LED / button panel
// Input register, pattern player, panel sequencer and result register.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_stall) carries one command beat: a 1 ms
//   tick with the sampled pin levels, a single-LED write, a pattern table
//   load, or playback start / stop. Every beat gives exactly one result beat
//   on the output channel (out_valid / out_stall) with the pin drive, the
//   latched button mask, the requested LED mask, the phase and the play flag
//   as they stand after that beat.
//   An accepted beat sits in the input register; once the result register is
//   free, it is carried through the player and panel logic into the result
//   register, which raises out_valid. One beat is accepted every cycle while
//   the receiver does not stall; the state update is a single pass of logic
//   between the input and result registers. When the receiver stalls, the
//   result register holds and the input register takes one more beat before
//   in_stall rises. Write the timing registers through cfg_we / cfg_index /
//   cfg_wdata only while no beat is in flight; the block does not enforce
//   this. Reset (rst_n low, synchronous) empties the input and result
//   registers, clears all masks and counters, selects the display phase and
//   loads 5 display ticks and 1 settle tick. The pattern table has no reset.
// ----------------------------------------------------------------------------
`default_nettype none

module led_button_mux_with_pattern_player_unit #(
  parameter int MAX_STEPS = lbm_pkg::MAX_STEPS_DEF,
  parameter int TIME_BITS = lbm_pkg::TIME_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // Configuration port
  input  wire logic                               cfg_we,
  input  wire logic [lbm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [lbm_pkg::CFG_W-1:0]          cfg_wdata,
  // Input channel
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [lbm_pkg::CMD_W-1:0]          in_cmd,
  input  wire logic [lbm_pkg::LED_IDX_W-1:0]      in_led_index,
  input  wire logic                               in_led_on,
  input  wire logic [lbm_pkg::STEP_IDX_W-1:0]     in_step_index,
  input  wire logic [lbm_pkg::LED_IDX_W-1:0]      in_step_led,
  input  wire logic [lbm_pkg::DUR_W-1:0]          in_step_duration,
  input  wire logic [lbm_pkg::PLEN_W-1:0]         in_pattern_length,
  input  wire logic [lbm_pkg::NUM_LEDS-1:0]       in_pin_levels,
  // Result channel
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [lbm_pkg::NUM_LEDS-1:0]            out_led_drive,
  output logic [lbm_pkg::NUM_LEDS-1:0]            out_pressed_buttons,
  output logic [lbm_pkg::NUM_LEDS-1:0]            out_lit_mask,
  output logic                                    out_in_scan,
  output logic                                    out_playing
);
  import lbm_pkg::*;

  logic            in_vld_r;
  lbm_item_t       item_r;
  logic            out_vld_r;
  logic            res_free;
  logic            upd;
  logic            in_take;
  lbm_play_stat_t  play_nxt;
  lbm_panel_stat_t panel_nxt;
  lbm_play_stat_t  play_res_r;
  lbm_panel_stat_t panel_res_r;

  // Handshake: the item in the input register moves on when the result
  // register is empty or being drained.
  assign res_free = !out_vld_r || !out_stall;
  assign upd      = in_vld_r && res_free;
  assign in_stall = in_vld_r && !res_free;
  assign in_take  = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (upd) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.cmd            <= in_cmd;
      item_r.led_index      <= in_led_index;
      item_r.led_on         <= in_led_on;
      item_r.step_index     <= in_step_index;
      item_r.step_led       <= in_step_led;
      item_r.step_duration  <= in_step_duration;
      item_r.pattern_length <= in_pattern_length;
      item_r.pin_levels     <= in_pin_levels;
    end
  end

  // Pattern player runs first; the panel sees its updated mask.
  lbm_player #(
    .MAX_STEPS (MAX_STEPS),
    .TIME_BITS (TIME_BITS)
  ) u_player (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd      (upd),
    .item     (item_r),
    .stat_nxt (play_nxt)
  );

  lbm_panel #(
    .TIME_BITS (TIME_BITS)
  ) u_panel (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .upd       (upd),
    .tick      (item_r.cmd == CMD_TICK),
    .pins      (item_r.pin_levels),
    .mask      (play_nxt.lit_mask),
    .stat_nxt  (panel_nxt)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (upd) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      play_res_r  <= play_nxt;
      panel_res_r <= panel_nxt;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_led_drive       = panel_res_r.drive;
  assign out_pressed_buttons = panel_res_r.pressed;
  assign out_lit_mask        = play_res_r.lit_mask;
  assign out_in_scan         = panel_res_r.in_scan;
  assign out_playing         = play_res_r.playing;

endmodule

`default_nettype wire
